// ===== hw/rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW = $clog2(QDepth);
	localparam int unsigned QCntW = $clog2(QDepth + 1);

	localparam logic [1:0] KIND_BYTE = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [3:0] ERR_NONE       = 4'd0;
	localparam logic [3:0] ERR_NO_QUOTE   = 4'd1;
	localparam logic [3:0] ERR_CTRL       = 4'd2;
	localparam logic [3:0] ERR_ESC_CUT    = 4'd3;
	localparam logic [3:0] ERR_BAD_ESC    = 4'd4;
	localparam logic [3:0] ERR_UNI_CUT    = 4'd5;
	localparam logic [3:0] ERR_BAD_HEX    = 4'd6;
	localparam logic [3:0] ERR_NO_LOW     = 4'd7;
	localparam logic [3:0] ERR_BAD_LOW    = 4'd8;
	localparam logic [3:0] ERR_LONE_LOW   = 4'd9;
	localparam logic [3:0] ERR_UNTERM     = 4'd10;

	// One classified request from the front to the back.
	typedef struct packed {
		logic [1:0]  kind;
		logic        utf8;   // value is a code point to encode
		logic [20:0] value;  // code point, or raw byte in [7:0]
		logic [3:0]  err;
	} cmd_t;

endpackage

// ===== hw/rtl/jsu_front.sv =====
// Front end: string parser that turns input requests into back-end commands.
module jsu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              action,
	input  logic [7:0]        in_byte,
	output logic              push,
	output jsu_pkg::cmd_t     cmd
);

	typedef enum logic [2:0] {
		PH_START, PH_RESYNC, PH_STR, PH_ESC, PH_HEX, PH_WANT_BSL, PH_WANT_U, PH_HEX_LOW
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  cnt_q, cnt_d;
	logic [11:0] acc_q, acc_d;
	logic [9:0]  high_q, high_d;
	logic        emit;
	logic [4:0]  hexv;
	logic [15:0] full;

	function automatic logic [4:0] hex_dec(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	assign hexv = hex_dec(in_byte);
	assign full = {acc_q, hexv[3:0]};
	assign push = accept && emit;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		high_d  = high_q;
		emit    = 1'b0;
		cmd     = '0;
		if (action) begin
			phase_d = PH_START;
			emit    = 1'b1;
			cmd.kind = jsu_pkg::KIND_ERR;
			case (phase_q)
				PH_STR:                 cmd.err = jsu_pkg::ERR_UNTERM;
				PH_ESC:                 cmd.err = jsu_pkg::ERR_ESC_CUT;
				PH_HEX, PH_HEX_LOW:     cmd.err = jsu_pkg::ERR_UNI_CUT;
				PH_WANT_BSL, PH_WANT_U: cmd.err = jsu_pkg::ERR_NO_LOW;
				default: begin
					emit     = 1'b0;
					cmd.kind = jsu_pkg::KIND_BYTE;
				end
			endcase
		end else begin
			case (phase_q)
				PH_START, PH_RESYNC: begin
					if (in_byte == 8'h22) begin
						phase_d = PH_STR;
					end else if (phase_q == PH_START) begin
						emit     = 1'b1;
						cmd.kind = jsu_pkg::KIND_ERR;
						cmd.err  = jsu_pkg::ERR_NO_QUOTE;
						phase_d  = PH_RESYNC;
					end
				end
				PH_STR: begin
					emit = 1'b1;
					if (in_byte == 8'h22) begin
						cmd.kind = jsu_pkg::KIND_END;
						phase_d  = PH_START;
					end else if (in_byte < 8'h20) begin
						cmd.kind = jsu_pkg::KIND_ERR;
						cmd.err  = jsu_pkg::ERR_CTRL;
						phase_d  = PH_RESYNC;
					end else if (in_byte == 8'h5C) begin
						emit    = 1'b0;
						phase_d = PH_ESC;
					end else begin
						cmd.value = {13'd0, in_byte};
					end
				end
				PH_ESC: begin
					emit    = 1'b1;
					phase_d = PH_STR;
					case (in_byte)
						8'h22, 8'h5C, 8'h2F: cmd.value = {13'd0, in_byte};
						8'h62: cmd.value = 21'h08;
						8'h66: cmd.value = 21'h0C;
						8'h6E: cmd.value = 21'h0A;
						8'h72: cmd.value = 21'h0D;
						8'h74: cmd.value = 21'h09;
						8'h75: begin
							emit    = 1'b0;
							phase_d = PH_HEX;
							cnt_d   = 2'd0;
							acc_d   = '0;
						end
						default: begin
							cmd.kind = jsu_pkg::KIND_ERR;
							cmd.err  = jsu_pkg::ERR_BAD_ESC;
							phase_d  = PH_RESYNC;
						end
					endcase
				end
				PH_WANT_BSL: begin
					if (in_byte == 8'h5C) begin
						phase_d = PH_WANT_U;
					end else begin
						emit     = 1'b1;
						cmd.kind = jsu_pkg::KIND_ERR;
						cmd.err  = jsu_pkg::ERR_NO_LOW;
						phase_d  = PH_RESYNC;
					end
				end
				PH_WANT_U: begin
					if (in_byte == 8'h75) begin
						phase_d = PH_HEX_LOW;
						cnt_d   = 2'd0;
						acc_d   = '0;
					end else begin
						emit     = 1'b1;
						cmd.kind = jsu_pkg::KIND_ERR;
						cmd.err  = jsu_pkg::ERR_NO_LOW;
						phase_d  = PH_RESYNC;
					end
				end
				default: begin
					if (!hexv[4]) begin
						emit     = 1'b1;
						cmd.kind = jsu_pkg::KIND_ERR;
						cmd.err  = jsu_pkg::ERR_BAD_HEX;
						phase_d  = PH_RESYNC;
					end else if (cnt_q != 2'd3) begin
						acc_d = full[11:0];
						cnt_d = cnt_q + 2'd1;
					end else begin
						cnt_d = 2'd0;
						acc_d = full[11:0];
						if (phase_q == PH_HEX) begin
							if (full[15:10] == 6'b110110) begin
								high_d  = full[9:0];
								phase_d = PH_WANT_BSL;
							end else if (full[15:10] == 6'b110111) begin
								emit     = 1'b1;
								cmd.kind = jsu_pkg::KIND_ERR;
								cmd.err  = jsu_pkg::ERR_LONE_LOW;
								phase_d  = PH_RESYNC;
							end else begin
								emit      = 1'b1;
								cmd.utf8  = 1'b1;
								cmd.value = {5'd0, full};
								phase_d   = PH_STR;
							end
						end else begin
							emit = 1'b1;
							if (full[15:10] != 6'b110111) begin
								cmd.kind = jsu_pkg::KIND_ERR;
								cmd.err  = jsu_pkg::ERR_BAD_LOW;
								phase_d  = PH_RESYNC;
							end else begin
								cmd.utf8  = 1'b1;
								cmd.value = {1'b0, high_q, full[9:0]} + 21'h10000;
								phase_d   = PH_STR;
							end
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			cnt_q   <= '0;
			acc_q   <= '0;
			high_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			acc_q   <= acc_d;
			high_q  <= high_d;
		end
	end

endmodule

// ===== hw/rtl/jsu_fifo.sv =====
// Command queue between the parser and the UTF-8 output stage.
module jsu_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsu_pkg::cmd_t     wdata,
	input  logic              pop,
	output jsu_pkg::cmd_t     rdata,
	output logic              full,
	output logic              empty
);

	jsu_pkg::cmd_t                mem_q [jsu_pkg::QDepth];
	logic [jsu_pkg::QPtrW-1:0]    wr_q, rd_q;
	logic [jsu_pkg::QCntW-1:0]    cnt_q;
	logic                         do_push, do_pop;

	assign full    = (cnt_q == jsu_pkg::QCntW'(jsu_pkg::QDepth));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == jsu_pkg::QPtrW'(jsu_pkg::QDepth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == jsu_pkg::QPtrW'(jsu_pkg::QDepth - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/jsu_back.sv =====
// Back end: expands commands into UTF-8 result bytes behind an output register.
module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  jsu_pkg::cmd_t     cmd,
	input  logic              cmd_empty,
	output logic              cmd_pop,
	output logic              result_valid,
	input  logic              result_ready,
	output logic [1:0]        kind,
	output logic [7:0]        out_byte,
	output logic [3:0]        error_code,
	output logic              last
);

	logic        busy_q;
	logic [20:0] cp_q;
	logic [1:0]  len_q, idx_q;
	logic        load;
	logic [1:0]  new_len;
	logic [7:0]  new_byte;

	function automatic logic [7:0] enc(input logic [20:0] cp, input logic [1:0] len,
	                                   input logic [1:0] idx);
		logic [7:0] b;
		logic [1:0] sh;
		b  = 8'd0;
		sh = len - idx;
		if (idx == 2'd0) begin
			case (len)
				2'd0:    b = {1'b0, cp[6:0]};
				2'd1:    b = {3'b110, cp[10:6]};
				2'd2:    b = {4'b1110, cp[15:12]};
				default: b = {5'b11110, cp[20:18]};
			endcase
		end else begin
			case (sh)
				2'd0:    b = {2'b10, cp[5:0]};
				2'd1:    b = {2'b10, cp[11:6]};
				default: b = {2'b10, cp[17:12]};
			endcase
		end
		return b;
	endfunction

	assign load    = !result_valid || result_ready;
	assign cmd_pop = load && !busy_q && !cmd_empty;

	always_comb begin
		new_len = 2'd0;
		if (cmd.utf8) begin
			if (cmd.value <= 21'h7F)        new_len = 2'd0;
			else if (cmd.value <= 21'h7FF)  new_len = 2'd1;
			else if (cmd.value <= 21'hFFFF) new_len = 2'd2;
			else                            new_len = 2'd3;
		end
		new_byte = cmd.utf8 ? enc(cmd.value, new_len, 2'd0) : cmd.value[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			busy_q       <= 1'b0;
			cp_q         <= '0;
			len_q        <= '0;
			idx_q        <= '0;
			kind         <= '0;
			out_byte     <= '0;
			error_code   <= '0;
			last         <= 1'b0;
		end else if (load) begin
			if (busy_q) begin
				result_valid <= 1'b1;
				kind         <= jsu_pkg::KIND_BYTE;
				error_code   <= jsu_pkg::ERR_NONE;
				out_byte     <= enc(cp_q, len_q, idx_q);
				last         <= (idx_q == len_q);
				busy_q       <= (idx_q != len_q);
				idx_q        <= idx_q + 2'd1;
			end else if (!cmd_empty) begin
				result_valid <= 1'b1;
				kind         <= cmd.kind;
				error_code   <= cmd.err;
				out_byte     <= new_byte;
				last         <= (new_len == 2'd0);
				busy_q       <= (new_len != 2'd0);
				cp_q         <= cmd.value;
				len_q        <= new_len;
				idx_q        <= 2'd1;
			end else begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// Input channel (item_valid/item_ready): one request per byte of a JSON
// string literal, starting at the opening quote, or an end-of-input marker
// (action = 1). Output channel (result_valid/result_ready): decoded UTF-8
// bytes (kind 0), an end marker on the closing quote (kind 1) or one
// numbered error (kind 2); last flags the final result of each request.
// The parser accepts one request per cycle while its command queue
// (4 entries) has room. The output stage emits one result per cycle while
// the receiver is ready; a \u escape or surrogate pair expands to up to
// four bytes, which the queue absorbs while the next escape is parsed.
// A request that gives results passes through the command queue and then
// the output register; requests that give no result (opening quotes,
// backslashes, hex digits before the last) only advance the parser.
// When the receiver stalls, the output register holds its result, the
// queue fills and item_ready drops until room is made.
// Reset (arst_n low) clears the parser to "waiting for opening quote",
// empties the queue and drops result_valid.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic       action,
	input  logic [7:0] in_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic [3:0] error_code,
	output logic       last
);

	jsu_pkg::cmd_t wcmd, rcmd;
	logic          accept, push, pop, full, empty;

	assign item_ready = !full;
	assign accept     = item_valid && item_ready;

	jsu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (action),
		.in_byte (in_byte),
		.push    (push),
		.cmd     (wcmd)
	);

	jsu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wcmd),
		.pop    (pop),
		.rdata  (rcmd),
		.full   (full),
		.empty  (empty)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (rcmd),
		.cmd_empty    (empty),
		.cmd_pop      (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.kind         (kind),
		.out_byte     (out_byte),
		.error_code   (error_code),
		.last         (last)
	);

endmodule
